// ===== rtl/core/keyed_hash_sensor_noise_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the keyed hash sensor noise block
// Implication checks that vanish when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef KEYED_HASH_SENSOR_NOISE_ASSERT_SVH
`define KEYED_HASH_SENSOR_NOISE_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication
`define KHSN_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("keyed hash noise check failed");
// Next-cycle implication
`define KHSN_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("keyed hash noise check failed");
`else
`define KHSN_ASSERT_IMPL(name, clk, rst, ante, cons)
`define KHSN_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/core/khsn_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// khsn_pkg
// Shared types, mixing constants and channel keys of the sensor noise block.
// ----------------------------------------------------------------------------
package khsn_pkg;

   // Mixing constants
   localparam logic [63:0] K1 = 64'h9E3779B97F4A7C15;
   localparam logic [63:0] K2 = 64'h517CC1B727220A95;
   localparam logic [63:0] M1 = 64'hFF51AFD7ED558CCD;
   localparam logic [63:0] M2 = 64'hC4CEB9FE1A85EC53;

   // Pipeline depth: input with ts parts, h1, m1 parts, h2, m2 parts, c, product, out
   localparam int NUM_STAGES = 8;
   localparam int NUM_AXES   = 3;

   // Sensor kinds
   localparam logic [1:0] KIND_ACCEL  = 2'd0;
   localparam logic [1:0] KIND_GYRO   = 2'd1;
   localparam logic [1:0] KIND_MAGNET = 2'd2;
   localparam logic [1:0] KIND_NONE   = 2'd3;

   // Register indexes
   localparam int          CSR_INDEX_W = 3;
   localparam int          CSR_DATA_W  = 32;
   localparam logic [2:0]  CSR_ENABLE  = 3'd0;
   localparam logic [2:0]  CSR_SEED    = 3'd1;
   localparam logic [2:0]  CSR_ACCEL   = 3'd2;
   localparam logic [2:0]  CSR_GYRO    = 3'd3;
   localparam logic [2:0]  CSR_MAGNET  = 3'd4;

   typedef struct packed {
      logic        enable;
      logic [31:0] seed;
      logic [15:0] accel_mag;
      logic [15:0] gyro_mag;
      logic [15:0] magnet_mag;
   } csr_cfg_type;

   localparam csr_cfg_type CFG_RESET = '{
      enable:     1'b0,
      seed:       32'd0,
      accel_mag:  16'd1311,
      gyro_mag:   16'd66,
      magnet_mag: 16'd32768
   };

   // Per-request side data that travels with the pipeline
   typedef struct packed {
      logic        active;
      logic [15:0] mag;
   } side_type;

   // Channel number times K1, folded at elaboration
   function automatic logic [63:0] chan_mult(input logic [15:0] chan);
      logic [63:0] prod;
      prod = {48'd0, chan} * K1;
      return prod;
   endfunction

   // Channel keys by kind and axis; the unused kind gets zeros
   localparam logic [63:0] CHAN_KEY [4][3] = '{
      '{chan_mult(16'h0AC1), chan_mult(16'h0AC2), chan_mult(16'h0AC3)},
      '{chan_mult(16'h06E1), chan_mult(16'h06E2), chan_mult(16'h06E3)},
      '{chan_mult(16'h0E61), chan_mult(16'h0E62), chan_mult(16'h0E63)},
      '{64'd0, 64'd0, 64'd0}
   };

endpackage
`default_nettype wire

// ===== rtl/core/khsn_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// khsn_req_if
// Request channel: sensor kind, timestamp and three axis samples.
// ----------------------------------------------------------------------------
interface khsn_req_if #(
   parameter int SAMPLE_WIDTH = 32
);
   logic                           valid;
   logic                           ready;
   logic [1:0]                     opcode;
   logic [63:0]                    sample_stamp;
   logic signed [SAMPLE_WIDTH-1:0] x_in;
   logic signed [SAMPLE_WIDTH-1:0] y_in;
   logic signed [SAMPLE_WIDTH-1:0] z_in;

   modport source (output valid, output opcode, output sample_stamp,
                   output x_in, output y_in, output z_in, input ready);
   modport sink   (input valid, input opcode, input sample_stamp,
                   input x_in, input y_in, input z_in, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/khsn_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// khsn_rsp_if
// Result channel: three noisy axis samples.
// ----------------------------------------------------------------------------
interface khsn_rsp_if #(
   parameter int SAMPLE_WIDTH = 32
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] x_out;
   logic signed [SAMPLE_WIDTH-1:0] y_out;
   logic signed [SAMPLE_WIDTH-1:0] z_out;

   modport source (output valid, output x_out, output y_out, output z_out,
                   input ready);
   modport sink   (input valid, input x_out, input y_out, input z_out,
                   output ready);
endinterface
`default_nettype wire

// ===== rtl/core/khsn_csr_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// khsn_csr_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface khsn_csr_if
   import khsn_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/khsn_csr.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "keyed_hash_sensor_noise_assert.svh"
// ----------------------------------------------------------------------------
// khsn_csr
// Configuration registers: enable, seed and the three kind magnitudes.
// ----------------------------------------------------------------------------
module khsn_csr
   import khsn_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   khsn_csr_if.sink    csr_bus,
   output csr_cfg_type cfg
);

   csr_cfg_type cfg_ff;
   csr_cfg_type cfg_in;

   // Always take writes
   assign csr_bus.ready = 1'b1;

   // Decode the write index, drop unknown indexes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_ENABLE: cfg_in.enable     = csr_bus.data[0];
            CSR_SEED:   cfg_in.seed       = csr_bus.data[31:0];
            CSR_ACCEL:  cfg_in.accel_mag  = csr_bus.data[15:0];
            CSR_GYRO:   cfg_in.gyro_mag   = csr_bus.data[15:0];
            CSR_MAGNET: cfg_in.magnet_mag = csr_bus.data[15:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

   `KHSN_ASSERT_NEXT(a_seed_write, clock, reset, csr_bus.valid && csr_bus.ready && csr_bus.index == CSR_SEED, cfg_ff.seed == $past(csr_bus.data))

endmodule
`default_nettype wire

// ===== rtl/core/khsn_cmul64.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// khsn_cmul64
// Low 64 bits of a 64-bit word times a constant: registered 32x32 partials,
// summed combinationally in the following stage.
// ----------------------------------------------------------------------------
module khsn_cmul64 #(
   parameter logic [63:0] MULT = 64'h0000000000000001
) (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] a,
   output logic [63:0] p
);

   logic [63:0] ll_ff;
   logic [31:0] hl_ff;
   logic [31:0] lh_ff;
   logic [63:0] ll_in;
   logic [31:0] hl_in;
   logic [31:0] lh_in;

   // Form partial products; upper cross terms only need their low halves
   always_comb begin
      ll_in = {32'd0, a[31:0]} * {32'd0, MULT[31:0]};
      hl_in = a[63:32] * MULT[31:0];
      lh_in = a[31:0] * MULT[63:32];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ll_ff <= ll_in;
         hl_ff <= hl_in;
         lh_ff <= lh_in;
      end
   end

   // Fold the cross terms into the upper half
   assign p = ll_ff + {hl_ff + lh_ff, 32'd0};

endmodule
`default_nettype wire

// ===== rtl/core/khsn_axis.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "keyed_hash_sensor_noise_assert.svh"
// ----------------------------------------------------------------------------
// khsn_axis
// One axis: fmix rounds, centred noise scaling and saturating add.
// ----------------------------------------------------------------------------
module khsn_axis
   import khsn_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 32
) (
   input  logic                           clock,
   input  logic [NUM_STAGES:2]            stage_en,
   input  logic [63:0]                    h0,
   input  logic signed [SAMPLE_WIDTH-1:0] samp_s1,
   input  logic [15:0]                    mag_s6,
   input  logic                           valid_s7,
   input  logic                           active_s7,
   output logic signed [SAMPLE_WIDTH-1:0] samp_out
);

   localparam int NOISE_W = 17;
   localparam int SUM_W   = ((SAMPLE_WIDTH > NOISE_W) ? SAMPLE_WIDTH : NOISE_W) + 1;
   localparam logic signed [SUM_W-1:0] SAT_HI =
      {{(SUM_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

   logic signed [SAMPLE_WIDTH-1:0] samp_ff [NUM_STAGES-1:2];
   logic [63:0]                    h1_ff;
   logic [63:0]                    h2_ff;
   logic signed [31:0]             c_ff;
   logic signed [47:0]             prod_ff;
   logic signed [SAMPLE_WIDTH-1:0] out_ff;
   logic [63:0]                    p1;
   logic [63:0]                    p2;
   logic [31:0]                    low32;
   logic signed [48:0]             prod_full;
   logic signed [NOISE_W-1:0]      noise;
   logic signed [SUM_W-1:0]        sum;
   logic signed [SAMPLE_WIDTH-1:0] out_in;

   // Carry the sample along beside the hash
   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         samp_ff[2] <= samp_s1;
      end
      for (int k = 3; k < NUM_STAGES; k++) begin
         if (stage_en[k]) begin
            samp_ff[k] <= samp_ff[k-1];
         end
      end
   end

   // First xor-shift
   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         h1_ff <= h0 ^ (h0 >> 33);
      end
   end

   khsn_cmul64 #(.MULT(M1)) u_mul_m1 (
      .clock (clock),
      .en    (stage_en[3]),
      .a     (h1_ff),
      .p     (p1)
   );

   // Second xor-shift
   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         h2_ff <= p1 ^ (p1 >> 33);
      end
   end

   khsn_cmul64 #(.MULT(M2)) u_mul_m2 (
      .clock (clock),
      .en    (stage_en[5]),
      .a     (h2_ff),
      .p     (p2)
   );

   // Last xor-shift on the low word, then centre by flipping the top bit
   assign low32 = p2[31:0] ^ {1'b0, p2[63:33]};

   always_ff @(posedge clock) begin
      if (stage_en[6]) begin
         c_ff <= {~low32[31], low32[30:0]};
      end
   end

   // Scale by the kind magnitude
   assign prod_full = c_ff * $signed({1'b0, mag_s6});

   always_ff @(posedge clock) begin
      if (stage_en[7]) begin
         prod_ff <= prod_full[47:0];
      end
   end

   // Arithmetic shift by 31 is the floor of the scaled noise
   assign noise = prod_ff[47:31];
   assign sum   = {{(SUM_W-SAMPLE_WIDTH){samp_ff[NUM_STAGES-1][SAMPLE_WIDTH-1]}},
                   samp_ff[NUM_STAGES-1]}
                + {{(SUM_W-NOISE_W){noise[NOISE_W-1]}}, noise};

   // Saturate, or pass the sample when noise is off
   always_comb begin
      priority if (!active_s7) begin
         out_in = samp_ff[NUM_STAGES-1];
      end else if (sum > SAT_HI) begin
         out_in = SAT_HI[SAMPLE_WIDTH-1:0];
      end else if (sum < SAT_LO) begin
         out_in = SAT_LO[SAMPLE_WIDTH-1:0];
      end else begin
         out_in = sum[SAMPLE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[NUM_STAGES]) begin
         out_ff <= out_in;
      end
   end

   assign samp_out = out_ff;

   `KHSN_ASSERT_NEXT(a_pass_through, clock, 1'b0, stage_en[NUM_STAGES] && valid_s7 && !active_s7, out_ff == $past(samp_ff[NUM_STAGES-1]))

endmodule
`default_nettype wire

// ===== rtl/core/keyed_hash_sensor_noise.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "keyed_hash_sensor_noise_assert.svh"
// ----------------------------------------------------------------------------
// keyed_hash_sensor_noise
// Adds keyed, timestamp-derived dither to three-axis Q16.16 sensor samples.
//
// Channels: req_bus takes one request (kind, timestamp, x/y/z) per
// valid/ready handshake; rsp_bus returns one noisy x/y/z result per request,
// in order. csr_bus writes the enable, seed and per-kind magnitudes; it is
// always ready and should only be written while no request is in flight.
// The stages are the timestamp product, three fmix stages split around the
// two 64-bit constant multiplies, the magnitude scaling and the saturating
// add. Throughput: one request per cycle while the receiver does not stall;
// the 64-bit multiplies are split into 32x32 partial products and
// pipelined, so nothing loops.
// Reset: clears all stage valid bits and loads the register defaults
// (noise off, seed zero). When the receiver stalls, full stages hold and
// empty stages still fill, so up to 8 requests are taken before req ready
// drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module keyed_hash_sensor_noise
   import khsn_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   khsn_req_if.sink    req_bus,
   khsn_rsp_if.source  rsp_bus,
   khsn_csr_if.sink    csr_bus
);

   csr_cfg_type                    cfg;
   logic [NUM_STAGES:1]            v_ff;
   logic [NUM_STAGES:1]            v_in;
   logic [NUM_STAGES:1]            en;
   side_type                       side_ff [NUM_STAGES-1:1];
   side_type                       side_in;
   logic [1:0]                     kind_ff;
   logic signed [SAMPLE_WIDTH-1:0] samp_s1_ff [NUM_AXES];
   logic signed [SAMPLE_WIDTH-1:0] samp_out [NUM_AXES];
   logic signed [SAMPLE_WIDTH-1:0] samp_req [NUM_AXES];
   logic [63:0]                    ts_key;

   khsn_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   // Stage enables: a stage loads when empty or when the next one moves
   always_comb begin
      en[NUM_STAGES] = !v_ff[NUM_STAGES] || rsp_bus.ready;
      for (int k = NUM_STAGES - 1; k >= 1; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   // Advance valid bits with the data
   always_comb begin
      v_in[1] = en[1] ? req_bus.valid : v_ff[1];
      for (int k = 2; k <= NUM_STAGES; k++) begin
         v_in[k] = en[k] ? v_ff[k-1] : v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_bus.ready = en[1];
   assign rsp_bus.valid = v_ff[NUM_STAGES];

   // Select magnitude and decide whether noise applies
   always_comb begin
      side_in.active = cfg.enable && (cfg.seed != 32'd0) && (req_bus.opcode != KIND_NONE);
      unique case (req_bus.opcode)
         KIND_ACCEL:  side_in.mag = cfg.accel_mag;
         KIND_GYRO:   side_in.mag = cfg.gyro_mag;
         KIND_MAGNET: side_in.mag = cfg.magnet_mag;
         default:     side_in.mag = 16'd0;
      endcase
   end

   assign samp_req[0] = req_bus.x_in;
   assign samp_req[1] = req_bus.y_in;
   assign samp_req[2] = req_bus.z_in;

   // Capture the request and shift side data down the pipeline
   always_ff @(posedge clock) begin
      if (en[1]) begin
         side_ff[1] <= side_in;
         kind_ff    <= req_bus.opcode;
         for (int a = 0; a < NUM_AXES; a++) begin
            samp_s1_ff[a] <= samp_req[a];
         end
      end
      for (int k = 2; k < NUM_STAGES; k++) begin
         if (en[k]) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // Timestamp product is common to all axes
   khsn_cmul64 #(.MULT(K2)) u_mul_ts (
      .clock (clock),
      .en    (en[1]),
      .a     (req_bus.sample_stamp),
      .p     (ts_key)
   );

   // Key each axis and run its hash chain
   for (genvar ax = 0; ax < NUM_AXES; ax++) begin : g_axis
      logic [63:0] h0;

      assign h0 = {32'd0, cfg.seed} ^ CHAN_KEY[kind_ff][ax] ^ ts_key;

      khsn_axis #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_axis (
         .clock     (clock),
         .stage_en  (en[NUM_STAGES:2]),
         .h0        (h0),
         .samp_s1   (samp_s1_ff[ax]),
         .mag_s6    (side_ff[6].mag),
         .valid_s7  (v_ff[7]),
         .active_s7 (side_ff[7].active),
         .samp_out  (samp_out[ax])
      );
   end

   assign rsp_bus.x_out = samp_out[0];
   assign rsp_bus.y_out = samp_out[1];
   assign rsp_bus.z_out = samp_out[2];

   `KHSN_ASSERT_IMPL(a_ready_only_when_full, clock, reset, !req_bus.ready, v_ff[1])
   `KHSN_ASSERT_IMPL(a_full_stall_blocks, clock, reset, (&v_ff) && !rsp_bus.ready, !req_bus.ready)

endmodule
`default_nettype wire
